[src/sgdmf_pkg.sv]
// Shared types and constants for the matrix-factorization update block.
`timescale 1ns / 1ps

package sgdmf_pkg;

    localparam int DATA_W    = 32;
    localparam int ROW_W     = 10;
    localparam int FIDX_W    = 4;
    localparam int FUNC_W    = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // Function codes of an input word
    localparam logic [FUNC_W-1:0] FUNC_LOAD_USER = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_ITEM = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RATING    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ_USER = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ_ITEM = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGULARIZATION = 1'd1;

    localparam logic [CFG_W-1:0] RATE_RESET   = 16'd655;
    localparam logic [CFG_W-1:0] LAMBDA_RESET = 16'd3277;

    // y = sat(c + m), sat(c - m), sat(m - c) with m = sat(floor(a*b / 2^16))
    typedef enum logic [1:0] {
        MAC_ADD  = 2'd0,
        MAC_SUB  = 2'd1,
        MAC_RSUB = 2'd2
    } mac_mode_t;

    typedef struct packed {
        logic                     issue;
        mac_mode_t                mode;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] c;
    } mac_req_t;

endpackage

[src/sgdmf_mac.sv]
// Shared two-stage multiply, scale, accumulate and saturate unit.
`timescale 1ns / 1ps

module sgdmf_mac
    import sgdmf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_req_t                 req,
    output logic signed [DATA_W-1:0] y
);

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [DATA_W-1:0] r;
        begin
            if (x > SAT_HI)
            begin
                r = SAT_HI[DATA_W-1:0];
            end
            else if (x < SAT_LO)
            begin
                r = SAT_LO[DATA_W-1:0];
            end
            else
            begin
                r = x[DATA_W-1:0];
            end
            return r;
        end
    endfunction

    logic signed [63:0]       prod_reg;
    logic signed [DATA_W-1:0] c_reg;
    mac_mode_t                mode_reg;
    logic                     v1_reg;
    logic signed [DATA_W-1:0] y_reg;

    logic signed [63:0]       shifted;
    logic signed [DATA_W-1:0] m;
    logic signed [33:0]       sum;
    logic signed [DATA_W-1:0] y_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.issue;
        end
    end

    // Stage 1: full product
    always_ff @(posedge clk)
    begin
        if (req.issue)
        begin
            prod_reg <= 64'(req.a) * 64'(req.b);
            c_reg    <= req.c;
            mode_reg <= req.mode;
        end
    end

    // Stage 2: floor scale, saturate, add, saturate
    always_comb
    begin
        shifted = prod_reg >>> 16;
        m       = sat32(shifted);
        case (mode_reg)
            MAC_ADD:  sum = 34'(c_reg) + 34'(m);
            MAC_SUB:  sum = 34'(c_reg) - 34'(m);
            MAC_RSUB: sum = 34'(m) - 34'(c_reg);
            default:  sum = 34'(c_reg);
        endcase
        y_next = sat32(64'(sum));
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

[src/sgdmf_table.sv]
// Factor table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module sgdmf_table #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14,
    parameter int DW    = 32
)(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/sgd_matrix_factor_update_unit.sv]
// Top level: sequencer, factor tables and shared MAC of the SGD factor update block.
`timescale 1ns / 1ps

// SGD matrix-factorization update. The block holds a user and an item factor
// table, FACTORS signed Q15.16 entries per row, in on-chip memory that is not
// cleared: load every entry before a rating or read touches it. A rating word
// (func 2) computes the residual r = rating - dot(u, v), updates the item row,
// then the user row from the new item values, and returns r. Loads (func 0/1)
// return zero, reads (func 3/4) return the entry; a factor index at or beyond
// FACTORS and func codes 5 to 7 return zero and change nothing. Row indexes
// wrap modulo MAX_USERS / MAX_ITEMS. The block takes one word at a time and
// stalls its input until the result has been handed to the output register;
// that register lets the next word in while the result waits downstream.
// A read adds a capture step over a load or unused func unless its factor
// index is out of range, and any word adds a row reduction when a table has
// fewer than 1024 rows. A rating takes longest; its time is set by the single
// shared MAC: per factor, one dependent operation for the dot product and three
// for each row update, each passing through the multiplier and the accumulate
// stage, plus a table read and a write-back or advance step per factor and
// pass. Configuration registers: learning_rate (index 0) and regularization
// (index 1), unsigned Q0.16; write them only when the block is idle.
// cfg_ready is always high.

module sgd_matrix_factor_update_unit
    import sgdmf_pkg::*;
#(
    parameter int MAX_USERS = 1024,
    parameter int MAX_ITEMS = 1024,
    parameter int FACTORS   = 16
)(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [FUNC_W-1:0]        func,
    input  logic [ROW_W-1:0]         user_row,
    input  logic [ROW_W-1:0]         item_row,
    input  logic [FIDX_W-1:0]        factor_index,
    input  logic signed [DATA_W-1:0] value,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] data,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    localparam int UDEPTH   = MAX_USERS * FACTORS;
    localparam int IDEPTH   = MAX_ITEMS * FACTORS;
    localparam int UAW      = (UDEPTH > 1) ? $clog2(UDEPTH) : 1;
    localparam int IAW      = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
    localparam int KW       = (FACTORS > 1) ? $clog2(FACTORS) : 1;
    localparam int RED_W    = $clog2(ROW_W);
    localparam int LIM_W    = ROW_W + 17;
    localparam bit NEED_RED = (MAX_USERS < (1 << ROW_W)) || (MAX_ITEMS < (1 << ROW_W));

    typedef enum logic [19:0] {
        ST_IDLE     = 20'h00001,
        ST_REDUCE   = 20'h00002,
        ST_BASE     = 20'h00004,
        ST_EXEC     = 20'h00008,
        ST_READ_CAP = 20'h00010,
        ST_R_RD     = 20'h00020,
        ST_R_OP     = 20'h00040,
        ST_R_NEXT   = 20'h00080,
        ST_I_RD     = 20'h00100,
        ST_I_T      = 20'h00200,
        ST_I_D      = 20'h00400,
        ST_I_V      = 20'h00800,
        ST_I_WR     = 20'h01000,
        ST_U_RD     = 20'h02000,
        ST_U_T      = 20'h04000,
        ST_U_D      = 20'h08000,
        ST_U_V      = 20'h10000,
        ST_U_WR     = 20'h20000,
        ST_WAIT     = 20'h40000,
        ST_DONE     = 20'h80000
    } state_t;

    // Control state
    state_t                   state_reg, state_next;
    state_t                   ret_reg, ret_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CFG_W-1:0]         rate_reg, rate_next;
    logic [CFG_W-1:0]         lambda_reg, lambda_next;

    // Payload
    logic [FUNC_W-1:0]        func_reg, func_next;
    logic [ROW_W-1:0]         urow_reg, urow_next;
    logic [ROW_W-1:0]         irow_reg, irow_next;
    logic [FIDX_W-1:0]        fidx_reg, fidx_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [RED_W-1:0]         red_cnt_reg, red_cnt_next;
    logic [UAW-1:0]           ubase_reg, ubase_next;
    logic [IAW-1:0]           ibase_reg, ibase_next;
    logic [KW-1:0]            k_reg, k_next;
    logic signed [DATA_W-1:0] r_reg, r_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic signed [DATA_W-1:0] data_reg, data_next;

    // Datapath wiring
    mac_req_t                 mac_req;
    logic signed [DATA_W-1:0] mac_y;
    logic                     user_we, item_we, user_re, item_re;
    logic [UAW-1:0]           user_addr;
    logic [IAW-1:0]           item_addr;
    logic [DATA_W-1:0]        user_wdata, item_wdata;
    logic [DATA_W-1:0]        user_q, item_q;
    logic                     use_fidx;
    logic                     fok;
    logic                     k_last;
    logic [LIM_W-1:0]         ulim, ilim;
    logic                     uhit, ihit;
    logic signed [DATA_W-1:0] rate_op, lambda_op;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign cfg_ready = 1'b1;

    assign fok       = (int'(fidx_reg) < FACTORS);
    assign k_last    = (k_reg == KW'(FACTORS - 1));
    assign rate_op   = $signed({{(DATA_W - CFG_W){1'b0}}, rate_reg});
    assign lambda_op = $signed({{(DATA_W - CFG_W){1'b0}}, lambda_reg});

    // Restoring row reduction: one shifted table size per cycle, high to low
    assign ulim = LIM_W'(MAX_USERS) << red_cnt_reg;
    assign ilim = LIM_W'(MAX_ITEMS) << red_cnt_reg;
    assign uhit = (LIM_W'(urow_reg) >= ulim);
    assign ihit = (LIM_W'(irow_reg) >= ilim);

    // Loads and reads address the named factor, the rating passes walk k
    assign use_fidx  = (state_reg == ST_EXEC);
    assign user_addr = ubase_reg + (use_fidx ? UAW'(fidx_reg) : UAW'(k_reg));
    assign item_addr = ibase_reg + (use_fidx ? IAW'(fidx_reg) : IAW'(k_reg));
    assign user_wdata = use_fidx ? value_reg : mac_y;
    assign item_wdata = use_fidx ? value_reg : mac_y;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        out_valid_next = out_valid_reg;
        rate_next      = rate_reg;
        lambda_next    = lambda_reg;
        func_next      = func_reg;
        urow_next      = urow_reg;
        irow_next      = irow_reg;
        fidx_next      = fidx_reg;
        value_next     = value_reg;
        red_cnt_next   = red_cnt_reg;
        ubase_next     = ubase_reg;
        ibase_next     = ibase_reg;
        k_next         = k_reg;
        r_next         = r_reg;
        res_next       = res_reg;
        data_next      = data_reg;
        user_we        = 1'b0;
        item_we        = 1'b0;
        user_re        = 1'b0;
        item_re        = 1'b0;
        mac_req.issue  = 1'b0;
        mac_req.mode   = MAC_ADD;
        mac_req.a      = '0;
        mac_req.b      = '0;
        mac_req.c      = '0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LEARNING_RATE:  rate_next   = cfg_data;
                CFG_REGULARIZATION: lambda_next = cfg_data;
                default:            rate_next   = rate_reg;
            endcase
        end

        // drop the output word once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next    = func;
                    urow_next    = user_row;
                    irow_next    = item_row;
                    fidx_next    = factor_index;
                    value_next   = value;
                    red_cnt_next = RED_W'(ROW_W - 1);
                    state_next   = NEED_RED ? ST_REDUCE : ST_BASE;
                end
            end
            ST_REDUCE:
            begin
                if (uhit)
                begin
                    urow_next = urow_reg - ulim[ROW_W-1:0];
                end
                if (ihit)
                begin
                    irow_next = irow_reg - ilim[ROW_W-1:0];
                end
                if (red_cnt_reg == '0)
                begin
                    state_next = ST_BASE;
                end
                else
                begin
                    red_cnt_next = red_cnt_reg - RED_W'(1);
                end
            end
            ST_BASE:
            begin
                ubase_next = UAW'(int'(urow_reg) * FACTORS);
                ibase_next = IAW'(int'(irow_reg) * FACTORS);
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                res_next   = '0;
                state_next = ST_DONE;
                unique case (func_reg)
                    FUNC_LOAD_USER: user_we = fok;
                    FUNC_LOAD_ITEM: item_we = fok;
                    FUNC_RATING:
                    begin
                        r_next     = value_reg;
                        k_next     = '0;
                        state_next = ST_R_RD;
                    end
                    FUNC_READ_USER:
                    begin
                        if (fok)
                        begin
                            user_re    = 1'b1;
                            state_next = ST_READ_CAP;
                        end
                    end
                    FUNC_READ_ITEM:
                    begin
                        if (fok)
                        begin
                            item_re    = 1'b1;
                            state_next = ST_READ_CAP;
                        end
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_READ_CAP:
            begin
                res_next   = (func_reg == FUNC_READ_USER) ? $signed(user_q) : $signed(item_q);
                state_next = ST_DONE;
            end

            // Residual pass: r = sat(r - mul(u, v))
            ST_R_RD:
            begin
                user_re    = 1'b1;
                item_re    = 1'b1;
                state_next = ST_R_OP;
            end
            ST_R_OP:
            begin
                mac_req.issue = 1'b1;
                mac_req.mode  = MAC_SUB;
                mac_req.a     = $signed(user_q);
                mac_req.b     = $signed(item_q);
                mac_req.c     = r_reg;
                ret_next      = ST_R_NEXT;
                state_next    = ST_WAIT;
            end
            ST_R_NEXT:
            begin
                r_next = mac_y;
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = ST_I_RD;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = ST_R_RD;
                end
            end

            // Item pass: t = mul(lam, v); d = sat(mul(r, u) - t); v = sat(v + mul(rate, d))
            ST_I_RD:
            begin
                user_re    = 1'b1;
                item_re    = 1'b1;
                state_next = ST_I_T;
            end
            ST_I_T:
            begin
                mac_req.issue = 1'b1;
                mac_req.mode  = MAC_ADD;
                mac_req.a     = lambda_op;
                mac_req.b     = $signed(item_q);
                ret_next      = ST_I_D;
                state_next    = ST_WAIT;
            end
            ST_I_D:
            begin
                mac_req.issue = 1'b1;
                mac_req.mode  = MAC_RSUB;
                mac_req.a     = r_reg;
                mac_req.b     = $signed(user_q);
                mac_req.c     = mac_y;
                ret_next      = ST_I_V;
                state_next    = ST_WAIT;
            end
            ST_I_V:
            begin
                mac_req.issue = 1'b1;
                mac_req.mode  = MAC_ADD;
                mac_req.a     = rate_op;
                mac_req.b     = mac_y;
                mac_req.c     = $signed(item_q);
                ret_next      = ST_I_WR;
                state_next    = ST_WAIT;
            end
            ST_I_WR:
            begin
                item_we = 1'b1;
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = ST_U_RD;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = ST_I_RD;
                end
            end

            // User pass, same steps on the freshly written item row
            ST_U_RD:
            begin
                user_re    = 1'b1;
                item_re    = 1'b1;
                state_next = ST_U_T;
            end
            ST_U_T:
            begin
                mac_req.issue = 1'b1;
                mac_req.mode  = MAC_ADD;
                mac_req.a     = lambda_op;
                mac_req.b     = $signed(user_q);
                ret_next      = ST_U_D;
                state_next    = ST_WAIT;
            end
            ST_U_D:
            begin
                mac_req.issue = 1'b1;
                mac_req.mode  = MAC_RSUB;
                mac_req.a     = r_reg;
                mac_req.b     = $signed(item_q);
                mac_req.c     = mac_y;
                ret_next      = ST_U_V;
                state_next    = ST_WAIT;
            end
            ST_U_V:
            begin
                mac_req.issue = 1'b1;
                mac_req.mode  = MAC_ADD;
                mac_req.a     = rate_op;
                mac_req.b     = mac_y;
                mac_req.c     = $signed(user_q);
                ret_next      = ST_U_WR;
                state_next    = ST_WAIT;
            end
            ST_U_WR:
            begin
                user_we = 1'b1;
                if (k_last)
                begin
                    res_next   = r_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = ST_U_RD;
                end
            end

            // Wait here while the MAC's second stage registers the result
            ST_WAIT:
            begin
                state_next = ret_reg;
            end
            ST_DONE:
            begin
                // hold until the output register is free or being emptied
                if (!out_valid_reg || !out_stall)
                begin
                    data_next      = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rate_reg      <= RATE_RESET;
            lambda_reg    <= LAMBDA_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
            rate_reg      <= rate_next;
            lambda_reg    <= lambda_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        urow_reg    <= urow_next;
        irow_reg    <= irow_next;
        fidx_reg    <= fidx_next;
        value_reg   <= value_next;
        red_cnt_reg <= red_cnt_next;
        ubase_reg   <= ubase_next;
        ibase_reg   <= ibase_next;
        k_reg       <= k_next;
        r_reg       <= r_next;
        res_reg     <= res_next;
        data_reg    <= data_next;
    end

    sgdmf_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .y     (mac_y)
    );

    sgdmf_table #(
        .DEPTH (UDEPTH),
        .AW    (UAW),
        .DW    (DATA_W)
    ) u_user_table (
        .clk   (clk),
        .we    (user_we),
        .waddr (user_addr),
        .wdata (user_wdata),
        .re    (user_re),
        .raddr (user_addr),
        .rdata (user_q)
    );

    sgdmf_table #(
        .DEPTH (IDEPTH),
        .AW    (IAW),
        .DW    (DATA_W)
    ) u_item_table (
        .clk   (clk),
        .we    (item_we),
        .waddr (item_addr),
        .wdata (item_wdata),
        .re    (item_re),
        .raddr (item_addr),
        .rdata (item_q)
    );

    // An accepted word keeps the input stalled in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accepting a word");

    // Each MAC operation depends on the previous one: never two issues in a row
    a_mac_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        mac_req.issue |=> !mac_req.issue)
        else $error("MAC issued while an operation is in flight");

    // The two tables are never written in the same cycle
    a_one_table_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(user_we && item_we))
        else $error("both factor tables written at once");

    // A new result word only comes from the completion step
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("output word raised outside completion");

endmodule

[verif/sgd_matrix_factor_update_unit_tb.sv]
// Self-checking testbench for the SGD matrix-factorization update unit.
`timescale 1ns / 1ps

module sgd_matrix_factor_update_unit_tb;
    import sgdmf_pkg::*;

    // Sizes of the instance under test; rows and factor indexes span the full ports
    localparam int N_USERS   = 1024;
    localparam int N_ITEMS   = 1024;
    localparam int N_FACTORS = 16;

    // Function codes the block must ignore
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO  = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_MID = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI  = 3'd7;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 225;
    localparam int POOL_ROWS   = 10;
    localparam int SETTLE      = 30;

    typedef struct packed {
        logic [FUNC_W-1:0]        fn;
        logic [ROW_W-1:0]         urow;
        logic [ROW_W-1:0]         irow;
        logic [FIDX_W-1:0]        fidx;
        logic signed [DATA_W-1:0] value;
    } word_t;

    // One row of the directed table: the word, and an expectation typed in by hand
    // where it is obvious; other rows take their expectation from the factor model.
    typedef struct packed {
        word_t                    w;
        logic                     typed;
        logic signed [DATA_W-1:0] want;
    } probe_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [FUNC_W-1:0]        func = FUNC_LOAD_USER;
    logic [ROW_W-1:0]         user_row = '0;
    logic [ROW_W-1:0]         item_row = '0;
    logic [FIDX_W-1:0]        factor_index = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] data;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = CFG_LEARNING_RATE;
    logic [CFG_W-1:0]         cfg_data = '0;

    sgd_matrix_factor_update_unit #(
        .MAX_USERS (N_USERS),
        .MAX_ITEMS (N_ITEMS),
        .FACTORS   (N_FACTORS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .user_row     (user_row),
        .item_row     (item_row),
        .factor_index (factor_index),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data         (data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Factor model: private copy of both tables and both registers.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] user_tab [0:N_USERS*N_FACTORS-1];
    logic signed [DATA_W-1:0] item_tab [0:N_ITEMS*N_FACTORS-1];
    logic [CFG_W-1:0]         step_rate   = RATE_RESET;
    logic [CFG_W-1:0]         step_lambda = LAMBDA_RESET;

    // Residuals, reads and load acknowledgments still owed by the block, oldest first
    logic signed [DATA_W-1:0] owed_data [$];
    int                       mismatches = 0;

    // Rows whose every factor has been loaded; ratings and reads draw from these
    int user_pool [$];
    int item_pool [$];

    initial
    begin
        for (int i = 0; i < N_USERS * N_FACTORS; i++) user_tab[i] = '0;
        for (int i = 0; i < N_ITEMS * N_FACTORS; i++) item_tab[i] = '0;
    end

    function automatic logic signed [DATA_W-1:0] sat32(input longint x);
        if (x > longint'(Q_MAX)) return Q_MAX;
        if (x < longint'(Q_MIN)) return Q_MIN;
        return x[DATA_W-1:0];
    endfunction

    // Q16 product with floor rounding; the arithmetic shift floors negative values
    function automatic logic signed [DATA_W-1:0] qmul(input longint a, input longint b);
        return sat32((a * b) >>> 16);
    endfunction

    // Apply one word to the model tables and return the data word it should produce.
    function automatic logic signed [DATA_W-1:0] factor_step(input word_t w);
        int                       ub;
        int                       ib;
        int                       k;
        logic signed [DATA_W-1:0] r;
        logic signed [DATA_W-1:0] d;
        ub = int'(w.urow) * N_FACTORS;
        ib = int'(w.irow) * N_FACTORS;
        case (w.fn)
            FUNC_LOAD_USER:
            begin
                user_tab[ub + int'(w.fidx)] = w.value;
                return '0;
            end
            FUNC_LOAD_ITEM:
            begin
                item_tab[ib + int'(w.fidx)] = w.value;
                return '0;
            end
            FUNC_READ_USER: return user_tab[ub + int'(w.fidx)];
            FUNC_READ_ITEM: return item_tab[ib + int'(w.fidx)];
            FUNC_RATING:
            begin
                // Residual first, then the item row, then the user row off the new items
                r = w.value;
                for (k = 0; k < N_FACTORS; k++)
                    r = sat32(longint'(r) - longint'(qmul(user_tab[ub + k], item_tab[ib + k])));
                for (k = 0; k < N_FACTORS; k++)
                begin
                    d = sat32(longint'(qmul(r, user_tab[ub + k]))
                              - longint'(qmul(step_lambda, item_tab[ib + k])));
                    item_tab[ib + k] = sat32(longint'(item_tab[ib + k])
                                             + longint'(qmul(step_rate, d)));
                end
                for (k = 0; k < N_FACTORS; k++)
                begin
                    d = sat32(longint'(qmul(r, item_tab[ib + k]))
                              - longint'(qmul(step_lambda, user_tab[ub + k])));
                    user_tab[ub + k] = sat32(longint'(user_tab[ub + k])
                                             + longint'(qmul(step_rate, d)));
                end
                return r;
            end
            default: return '0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Random wait per word, with occasional calm stretches of no waiting
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) calm = $urandom_range(20, 60);
        return $urandom_range(0, 7);
    endfunction

    // Mostly values within +-2.0, some extremes, some anywhere in the 32-bit range
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return DATA_W'($urandom);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return DATA_W'(int'($urandom_range(0, 262143)) - 131072);
        endcase
    endfunction

    function automatic word_t noise_word(input logic [FUNC_W-1:0] fn);
        word_t w;
        w.fn    = fn;
        w.urow  = ROW_W'($urandom);
        w.irow  = ROW_W'($urandom);
        w.fidx  = FIDX_W'($urandom);
        w.value = pick_value();
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    int tx_calm = 0;

    // Present one word, hold it until the block takes it, then log what it owes.
    // Valid is never lowered after acceptance here: the next call either drops it
    // for a gap or drives the next word in the same step.
    task automatic send_word(input word_t w, input logic typed,
                             input logic signed [DATA_W-1:0] want);
        int                       gap;
        logic signed [DATA_W-1:0] model_data;
        gap = draw_wait(tx_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= w.fn;
        user_row     <= w.urow;
        item_row     <= w.irow;
        factor_index <= w.fidx;
        value        <= w.value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        model_data = factor_step(w);
        owed_data.push_back(typed ? want : model_data);
    endtask

    // Drop valid and wait for every owed word to come back
    task automatic drain();
        in_valid <= 1'b0;
        while (owed_data.size() != 0) @(posedge clk);
    endtask

    // Write both registers back to back; valid stays high between the two words
    task automatic set_rates(input logic [CFG_W-1:0] rate, input logic [CFG_W-1:0] lambda);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_LEARNING_RATE;
        cfg_data  <= rate;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        step_rate = rate;
        cfg_index <= CFG_REGULARIZATION;
        cfg_data  <= lambda;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        step_lambda = lambda;
        cfg_valid <= 1'b0;
    endtask

    // Load all factors of one row, then record the row as safe to rate and read
    task automatic fill_row(input logic user_side, input int row);
        word_t w;
        int    k;
        for (k = 0; k < N_FACTORS; k++)
        begin
            w       = noise_word(user_side ? FUNC_LOAD_USER : FUNC_LOAD_ITEM);
            w.fidx  = FIDX_W'(k);
            if (user_side) w.urow = ROW_W'(row);
            else           w.irow = ROW_W'(row);
            send_word(w, 1'b0, '0);
        end
        if (user_side)
        begin
            if (user_pool.size() < POOL_ROWS) user_pool.push_back(row);
            else user_pool[$urandom_range(0, POOL_ROWS - 1)] = row;
        end
        else
        begin
            if (item_pool.size() < POOL_ROWS) item_pool.push_back(row);
            else item_pool[$urandom_range(0, POOL_ROWS - 1)] = row;
        end
    endtask

    // One random step of traffic; the largest share of steps rates fully loaded rows
    task automatic random_traffic(output int words);
        word_t w;
        int    pick;
        logic  side;
        pick = $urandom_range(0, 99);
        side = 1'($urandom_range(0, 1));
        if (user_pool.size() == 0 || item_pool.size() == 0 || pick < 6)
        begin
            if (user_pool.size() == 0) side = 1'b1;
            else if (item_pool.size() == 0) side = 1'b0;
            fill_row(side, $urandom_range(0, N_USERS - 1));
            words = N_FACTORS;
        end
        else if (pick < 50)
        begin
            w      = noise_word(FUNC_RATING);
            w.urow = ROW_W'(user_pool[$urandom_range(0, user_pool.size() - 1)]);
            w.irow = ROW_W'(item_pool[$urandom_range(0, item_pool.size() - 1)]);
            send_word(w, 1'b0, '0);
            words = 1;
        end
        else if (pick < 72)
        begin
            // Read a factor of a loaded row
            w = noise_word(side ? FUNC_READ_USER : FUNC_READ_ITEM);
            if (side) w.urow = ROW_W'(user_pool[$urandom_range(0, user_pool.size() - 1)]);
            else      w.irow = ROW_W'(item_pool[$urandom_range(0, item_pool.size() - 1)]);
            send_word(w, 1'b0, '0);
            words = 1;
        end
        else if (pick < 92)
        begin
            // Lone load anywhere, sometimes read straight back
            w = noise_word(side ? FUNC_LOAD_USER : FUNC_LOAD_ITEM);
            send_word(w, 1'b0, '0);
            words = 1;
            if ($urandom_range(0, 1) == 1)
            begin
                w.fn    = side ? FUNC_READ_USER : FUNC_READ_ITEM;
                w.value = pick_value();
                send_word(w, 1'b0, '0);
                words = 2;
            end
        end
        else
        begin
            send_word(noise_word(FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI))),
                      1'b0, '0);
            words = 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table. User row 0 is preloaded with the largest value in every
    // factor and item row 1023 with the most negative, so ratings on that pair
    // saturate in every stage.
    // ------------------------------------------------------------------
    localparam int N_PROBES = 16;

    probe_t probe_tab [0:N_PROBES-1] = '{
        '{'{FUNC_READ_USER, 10'd0,    10'd0,    4'd0,  32'sd0},           1'b1, Q_MAX},
        '{'{FUNC_READ_ITEM, 10'd0,    10'd1023, 4'd15, 32'sd0},           1'b1, Q_MIN},
        '{'{FUNC_RATING,    10'd0,    10'd1023, 4'd0,  32'sd0},           1'b0, 32'sd0},
        '{'{FUNC_RATING,    10'd0,    10'd1023, 4'd15, Q_MIN},            1'b0, 32'sd0},
        '{'{FUNC_READ_USER, 10'd0,    10'd1023, 4'd7,  32'sd0},           1'b0, 32'sd0},
        '{'{FUNC_READ_ITEM, 10'd1023, 10'd1023, 4'd8,  32'sd0},           1'b0, 32'sd0},
        '{'{FUNC_LOAD_USER, 10'd0,    10'd0,    4'd15, 32'sd0},           1'b1, 32'sd0},
        '{'{FUNC_LOAD_ITEM, 10'd1023, 10'd1023, 4'd0,  -32'sd1},          1'b1, 32'sd0},
        '{'{FUNC_READ_ITEM, 10'd0,    10'd1023, 4'd0,  Q_MAX},            1'b1, -32'sd1},
        '{'{FUNC_UNUSED_LO, 10'd1023, 10'd1023, 4'd15, -32'sd1},          1'b1, 32'sd0},
        '{'{FUNC_UNUSED_MID, 10'd0,   10'd0,    4'd0,  32'sd0},           1'b1, 32'sd0},
        '{'{FUNC_UNUSED_HI, 10'h2AA,  10'h155,  4'hA,  32'sh5555_AAAA},   1'b1, 32'sd0},
        '{'{FUNC_RATING,    10'd0,    10'd1023, 4'd5,  Q_MAX},            1'b0, 32'sd0},
        '{'{FUNC_READ_USER, 10'd0,    10'd0,    4'd15, 32'sd0},           1'b0, 32'sd0},
        '{'{FUNC_LOAD_USER, 10'd0,    10'd512,  4'd3,  32'sh0001_0000},   1'b1, 32'sd0},
        '{'{FUNC_READ_USER, 10'd0,    10'd0,    4'd3,  32'sd0},           1'b1, 32'sh0001_0000}
    };

    // ------------------------------------------------------------------
    // Stimulus: reset, preload, directed table at reset rates, then random
    // phases that each start from an idle block with a fresh pair of rates.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] phase_rate   [0:PHASES-1] = '{16'hFFFF, 16'd0, 16'hFFFF, 16'd0,
                                                    16'd8192, 16'd655};
    logic [CFG_W-1:0] phase_lambda [0:PHASES-1] = '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF,
                                                    16'd1024, 16'd3277};

    initial
    begin : stimulus
        word_t w;
        int    k;
        int    phase;
        int    sent;
        int    words;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Preload the saturating pair
        for (k = 0; k < N_FACTORS; k++)
        begin
            w = '{FUNC_LOAD_USER, 10'd0, 10'd0, FIDX_W'(k), Q_MAX};
            send_word(w, 1'b1, '0);
            w = '{FUNC_LOAD_ITEM, 10'd0, 10'd1023, FIDX_W'(k), Q_MIN};
            send_word(w, 1'b1, '0);
        end
        user_pool.push_back(0);
        item_pool.push_back(N_ITEMS - 1);

        for (k = 0; k < N_PROBES; k++)
            send_word(probe_tab[k].w, probe_tab[k].typed, probe_tab[k].want);

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            set_rates(phase_rate[phase], phase_lambda[phase]);
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                random_traffic(words);
                sent += words;
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: stall at random after each word, compare against the
    // oldest owed word.
    // ------------------------------------------------------------------
    int                       rx_hold = 0;
    int                       rx_calm = 0;
    logic signed [DATA_W-1:0] rx_want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_data.size() == 0)
                begin
                    $error("unexpected data word: actual %h", data);
                    mismatches++;
                end
                else
                begin
                    rx_want = owed_data.pop_front();
                    if (data !== rx_want)
                    begin
                        $error("data: expected %h, actual %h", rx_want, data);
                        mismatches++;
                    end
                end
                rx_hold = draw_wait(rx_calm);
            end
            else if (rx_hold > 0)
            begin
                rx_hold--;
            end
            out_stall <= (rx_hold != 0);
        end
    end

    // Watchdog well beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
src/sgdmf_pkg.sv
src/sgdmf_mac.sv
src/sgdmf_table.sv
src/sgd_matrix_factor_update_unit.sv
verif/sgd_matrix_factor_update_unit_tb.sv
